FILE: src/imm_pkg.sv
package imm_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned IDX_W = 3;
   localparam int unsigned DIM_W = 4;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      ACT_LOAD_A = 2'd0,
      ACT_LOAD_B = 2'd1,
      ACT_START = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_ROWS_A = 2'd0,
      REG_INNER_DIM = 2'd1,
      REG_COLS_B = 2'd2,
      REG_UNUSED = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WAIT = 3'b010,
      ST_ISSUE = 3'b100
   } seq_state_type;

   typedef struct packed {
      action_type action;
      logic [IDX_W-1:0] elem_row;
      logic [IDX_W-1:0] elem_col;
      logic signed [DATA_W-1:0] elem_value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] out_row;
      logic [IDX_W-1:0] out_col;
      logic signed [DATA_W-1:0] product_value;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last_k;
      logic last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } ctl_type;

endpackage

FILE: src/imm_store.sv
module imm_store #(
   parameter int unsigned MAX_DIM = 8,
   parameter int unsigned AW = 6
) (
   input logic clock,
   input logic wr_a_i,
   input logic wr_b_i,
   input logic [AW-1:0] wr_addr_i,
   input logic [imm_pkg::DATA_W-1:0] wr_data_i,
   input logic [AW-1:0] rd_addr_a_i,
   input logic [AW-1:0] rd_addr_b_i,
   output logic [imm_pkg::DATA_W-1:0] rd_data_a_o,
   output logic [imm_pkg::DATA_W-1:0] rd_data_b_o
);

   localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;

   logic [imm_pkg::DATA_W-1:0] a_store_ff [DEPTH];
   logic [imm_pkg::DATA_W-1:0] b_store_ff [DEPTH];
   logic [imm_pkg::DATA_W-1:0] rd_a_ff;
   logic [imm_pkg::DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_a_i) begin
         a_store_ff[wr_addr_i] <= wr_data_i;
      end
      rd_a_ff <= a_store_ff[rd_addr_a_i];
   end

   always_ff @(posedge clock) begin
      if (wr_b_i) begin
         b_store_ff[wr_addr_i] <= wr_data_i;
      end
      rd_b_ff <= b_store_ff[rd_addr_b_i];
   end

   assign rd_data_a_o = rd_a_ff;
   assign rd_data_b_o = rd_b_ff;

endmodule

FILE: src/imm_mac.sv
module imm_mac (
   input logic clock,
   input logic reset,
   input imm_pkg::ctl_type ctl_i,
   input logic [imm_pkg::DATA_W-1:0] a_i,
   input logic [imm_pkg::DATA_W-1:0] b_i,
   output logic busy_o,
   output logic res_valid_o,
   output imm_pkg::rsp_type res_o
);

   imm_pkg::ctl_type ctl_d1_ff;
   imm_pkg::ctl_type ctl_d2_ff;
   logic [imm_pkg::DATA_W-1:0] prod_ff;
   logic [imm_pkg::DATA_W-1:0] prod_in;
   logic [imm_pkg::DATA_W-1:0] acc_ff;
   logic [imm_pkg::DATA_W-1:0] acc_in;

   // Only the low word of the product is kept, which is the same for signed operands.
   assign prod_in = imm_pkg::DATA_W'(a_i * b_i);
   assign acc_in = ctl_d2_ff.first ? prod_ff : acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_d1_ff <= '0;
         ctl_d2_ff <= '0;
      end else begin
         ctl_d1_ff <= ctl_i;
         ctl_d2_ff <= ctl_d1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_d1_ff.valid) begin
         prod_ff <= prod_in;
      end
      if (ctl_d2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign busy_o = ctl_d1_ff.valid | ctl_d2_ff.valid;
   assign res_valid_o = ctl_d2_ff.valid & ctl_d2_ff.last_k;
   assign res_o.out_row = ctl_d2_ff.row;
   assign res_o.out_col = ctl_d2_ff.col;
   assign res_o.product_value = acc_in;
   assign res_o.last = ctl_d2_ff.last;

   a_terms_contiguous : assert property (@(posedge clock) disable iff (reset)
      ctl_d2_ff.valid && !ctl_d2_ff.first |-> $past(ctl_d2_ff.valid))
      else $error("Accumulation term arrived without its predecessor.");

   a_first_pipe : assert property (@(posedge clock) disable iff (reset)
      ctl_d1_ff.valid && !ctl_d1_ff.first |-> ctl_d2_ff.valid && !ctl_d2_ff.last_k)
      else $error("Element terms interleaved in the multiply pipeline.");

endmodule

FILE: src/imm_seq.sv
module imm_seq #(
   parameter int unsigned MAX_DIM = 8,
   parameter int unsigned AW = 6
) (
   input logic clock,
   input logic reset,
   input logic start_i,
   input logic [imm_pkg::DIM_W-1:0] rows_a_i,
   input logic [imm_pkg::DIM_W-1:0] inner_dim_i,
   input logic [imm_pkg::DIM_W-1:0] cols_b_i,
   input logic mac_busy_i,
   input logic out_free_i,
   output logic idle_o,
   output imm_pkg::ctl_type ctl_o,
   output logic [AW-1:0] addr_a_o,
   output logic [AW-1:0] addr_b_o
);

   localparam int unsigned CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam logic [imm_pkg::DIM_W-1:0] DIM_MAX = imm_pkg::DIM_W'(MAX_DIM);

   imm_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0] r_ff, r_in;
   logic [CW-1:0] c_ff, c_in;
   logic [CW-1:0] k_ff, k_in;
   logic fin_ff, fin_in;
   logic [imm_pkg::DIM_W-1:0] nr, nk, nc;
   logic last_k, last_c, last_r;

   function automatic logic [imm_pkg::DIM_W-1:0] clamp_dim(
      input logic [imm_pkg::DIM_W-1:0] v
   );
      logic [imm_pkg::DIM_W-1:0] res;
      if (v == '0) begin
         res = imm_pkg::DIM_W'(1);
      end else if (v > DIM_MAX) begin
         res = DIM_MAX;
      end else begin
         res = v;
      end
      return res;
   endfunction

   assign nr = clamp_dim(rows_a_i);
   assign nk = clamp_dim(inner_dim_i);
   assign nc = clamp_dim(cols_b_i);
   assign last_k = imm_pkg::DIM_W'(k_ff) == nk - imm_pkg::DIM_W'(1);
   assign last_c = imm_pkg::DIM_W'(c_ff) == nc - imm_pkg::DIM_W'(1);
   assign last_r = imm_pkg::DIM_W'(r_ff) == nr - imm_pkg::DIM_W'(1);

   always_comb begin
      state_in = state_ff;
      r_in = r_ff;
      c_in = c_ff;
      k_in = k_ff;
      fin_in = fin_ff;
      case (state_ff)
         imm_pkg::ST_IDLE: begin
            if (start_i) begin
               r_in = '0;
               c_in = '0;
               k_in = '0;
               fin_in = 1'b0;
               state_in = imm_pkg::ST_WAIT;
            end
         end
         imm_pkg::ST_WAIT: begin
            if (!mac_busy_i && out_free_i) begin
               state_in = fin_ff ? imm_pkg::ST_IDLE : imm_pkg::ST_ISSUE;
            end
         end
         imm_pkg::ST_ISSUE: begin
            if (last_k) begin
               k_in = '0;
               state_in = imm_pkg::ST_WAIT;
               if (last_c) begin
                  c_in = '0;
                  if (last_r) begin
                     fin_in = 1'b1;
                  end else begin
                     r_in = r_ff + CW'(1);
                  end
               end else begin
                  c_in = c_ff + CW'(1);
               end
            end else begin
               k_in = k_ff + CW'(1);
            end
         end
         default: begin
            state_in = imm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imm_pkg::ST_IDLE;
         fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      c_ff <= c_in;
      k_ff <= k_in;
   end

   assign idle_o = state_ff == imm_pkg::ST_IDLE;
   assign ctl_o.valid = state_ff == imm_pkg::ST_ISSUE;
   assign ctl_o.first = k_ff == '0;
   assign ctl_o.last_k = last_k;
   assign ctl_o.last = last_r & last_c;
   assign ctl_o.row = imm_pkg::IDX_W'(r_ff);
   assign ctl_o.col = imm_pkg::IDX_W'(c_ff);
   assign addr_a_o = AW'(int'(r_ff) * MAX_DIM + int'(k_ff));
   assign addr_b_o = AW'(int'(k_ff) * MAX_DIM + int'(c_ff));

   a_idle_drained : assert property (@(posedge clock) disable iff (reset)
      state_ff == imm_pkg::ST_IDLE && !$past(start_i) |-> !mac_busy_i)
      else $error("Sequencer idle while products are still in flight.");

   a_issue_after_wait : assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == imm_pkg::ST_ISSUE) |-> k_ff == '0 && $past(!mac_busy_i))
      else $error("New element issued before the previous one drained.");

endmodule

FILE: src/integer_matrix_multiply.sv
// A load transfer writes one element of A or B.
// A start runs the product on one multiply-accumulate unit behind registered store reads.
// Each dimension is taken as 1 to MAX_DIM. The product elements are computed one at a time:
// an element's terms are issued only once the previous element has left the multiply-accumulate
// unit and the output register is free, and no new transfer is taken until the last one has left.
// Synchronous reset clears control and sets all dimensions to one; stores keep their data.
module integer_matrix_multiply #(
   parameter int unsigned MAX_DIM = 8
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input imm_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output imm_pkg::rsp_type rsp_data,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [imm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [imm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [imm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

   logic [imm_pkg::DIM_W-1:0] rows_a_ff;
   logic [imm_pkg::DIM_W-1:0] inner_dim_ff;
   logic [imm_pkg::DIM_W-1:0] cols_b_ff;
   logic csr_write;
   imm_pkg::reg_index_type csr_index;

   logic req_accept;
   logic in_range;
   logic wr_a, wr_b;
   logic [AW-1:0] wr_addr;
   logic start;

   logic seq_idle;
   imm_pkg::ctl_type ctl;
   logic [AW-1:0] addr_a, addr_b;
   logic [imm_pkg::DATA_W-1:0] data_a, data_b;
   logic mac_busy;
   logic res_valid;
   imm_pkg::rsp_type res;
   logic out_free;

   logic rsp_valid_ff, rsp_valid_in;
   imm_pkg::rsp_type rsp_data_ff;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index = imm_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= imm_pkg::DIM_W'(1);
         inner_dim_ff <= imm_pkg::DIM_W'(1);
         cols_b_ff <= imm_pkg::DIM_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            imm_pkg::REG_ROWS_A: begin
               rows_a_ff <= csr_pwdata[imm_pkg::DIM_W-1:0];
            end
            imm_pkg::REG_INNER_DIM: begin
               inner_dim_ff <= csr_pwdata[imm_pkg::DIM_W-1:0];
            end
            imm_pkg::REG_COLS_B: begin
               cols_b_ff <= csr_pwdata[imm_pkg::DIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         imm_pkg::REG_ROWS_A: begin
            csr_prdata = imm_pkg::CSR_DATA_W'(rows_a_ff);
         end
         imm_pkg::REG_INNER_DIM: begin
            csr_prdata = imm_pkg::CSR_DATA_W'(inner_dim_ff);
         end
         imm_pkg::REG_COLS_B: begin
            csr_prdata = imm_pkg::CSR_DATA_W'(cols_b_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign req_stall = !seq_idle;
   assign req_accept = req_valid & !req_stall;
   assign in_range = (int'(req_data.elem_row) < MAX_DIM) && (int'(req_data.elem_col) < MAX_DIM);
   assign wr_a = req_accept && in_range && req_data.action == imm_pkg::ACT_LOAD_A;
   assign wr_b = req_accept && in_range && req_data.action == imm_pkg::ACT_LOAD_B;
   assign wr_addr = AW'(int'(req_data.elem_row) * MAX_DIM + int'(req_data.elem_col));
   assign start = req_accept && req_data.action == imm_pkg::ACT_START;

   imm_store #(
      .MAX_DIM(MAX_DIM),
      .AW(AW)
   ) u_store (
      .clock(clock),
      .wr_a_i(wr_a),
      .wr_b_i(wr_b),
      .wr_addr_i(wr_addr),
      .wr_data_i(req_data.elem_value),
      .rd_addr_a_i(addr_a),
      .rd_addr_b_i(addr_b),
      .rd_data_a_o(data_a),
      .rd_data_b_o(data_b)
   );

   imm_seq #(
      .MAX_DIM(MAX_DIM),
      .AW(AW)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .start_i(start),
      .rows_a_i(rows_a_ff),
      .inner_dim_i(inner_dim_ff),
      .cols_b_i(cols_b_ff),
      .mac_busy_i(mac_busy),
      .out_free_i(out_free),
      .idle_o(seq_idle),
      .ctl_o(ctl),
      .addr_a_o(addr_a),
      .addr_b_o(addr_b)
   );

   imm_mac u_mac (
      .clock(clock),
      .reset(reset),
      .ctl_i(ctl),
      .a_i(data_a),
      .b_i(data_b),
      .busy_o(mac_busy),
      .res_valid_o(res_valid),
      .res_o(res)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !rsp_valid_ff || !rsp_stall)
      else $error("Product element arrived while the output register was held.");

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall)
      else $error("Block took a new transfer right after a start.");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int ITEM_TARGET = 480;
   localparam int CALM_FROM = 420;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 400000;

   class matrix_product_tracker;
      logic [imm_pkg::DATA_W-1:0] a_mem [64];
      logic [imm_pkg::DATA_W-1:0] b_mem [64];
      logic [imm_pkg::DIM_W-1:0] rows_a;
      logic [imm_pkg::DIM_W-1:0] inner_dim;
      logic [imm_pkg::DIM_W-1:0] cols_b;
      imm_pkg::rsp_type pending_elements [$];
      int errors;
      int checked;

      function new();
         rows_a = 4'd1;
         inner_dim = 4'd1;
         cols_b = 4'd1;
         errors = 0;
         checked = 0;
      endfunction

      function int clamp_dim(logic [imm_pkg::DIM_W-1:0] raw);
         if (raw == 0) return 1;
         if (raw > 8) return 8;
         return int'(raw);
      endfunction

      function void write_reg(imm_pkg::reg_index_type idx,
            logic [imm_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            imm_pkg::REG_ROWS_A: rows_a = value[imm_pkg::DIM_W-1:0];
            imm_pkg::REG_INNER_DIM: inner_dim = value[imm_pkg::DIM_W-1:0];
            imm_pkg::REG_COLS_B: cols_b = value[imm_pkg::DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [imm_pkg::CSR_DATA_W-1:0] reg_value(imm_pkg::reg_index_type idx);
         case (idx)
            imm_pkg::REG_ROWS_A:
               return {{(imm_pkg::CSR_DATA_W-imm_pkg::DIM_W){1'b0}}, rows_a};
            imm_pkg::REG_INNER_DIM:
               return {{(imm_pkg::CSR_DATA_W-imm_pkg::DIM_W){1'b0}}, inner_dim};
            imm_pkg::REG_COLS_B:
               return {{(imm_pkg::CSR_DATA_W-imm_pkg::DIM_W){1'b0}}, cols_b};
            default: return '0;
         endcase
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      function void note_transfer(imm_pkg::req_type item);
         int nr;
         int nk;
         int nc;
         logic [imm_pkg::DATA_W-1:0] sum;
         imm_pkg::rsp_type element;
         case (item.action)
            imm_pkg::ACT_LOAD_A: a_mem[{item.elem_row, item.elem_col}] = item.elem_value;
            imm_pkg::ACT_LOAD_B: b_mem[{item.elem_row, item.elem_col}] = item.elem_value;
            imm_pkg::ACT_START: begin
               nr = clamp_dim(rows_a);
               nk = clamp_dim(inner_dim);
               nc = clamp_dim(cols_b);
               for (int r = 0; r < nr; r++) begin
                  for (int c = 0; c < nc; c++) begin
                     sum = '0;
                     for (int k = 0; k < nk; k++) begin
                        sum = sum + a_mem[{r[2:0], k[2:0]}] * b_mem[{k[2:0], c[2:0]}];
                     end
                     element.out_row = r[imm_pkg::IDX_W-1:0];
                     element.out_col = c[imm_pkg::IDX_W-1:0];
                     element.product_value = sum;
                     element.last = (r == nr - 1) && (c == nc - 1);
                     pending_elements.push_back(element);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      task check_element(imm_pkg::rsp_type got);
         imm_pkg::rsp_type want;
         if (pending_elements.size() == 0) begin
            report($sformatf("unexpected element row %0d col %0d value %0h",
               got.out_row, got.out_col, got.product_value));
            return;
         end
         want = pending_elements.pop_front();
         checked++;
         if (got.out_row !== want.out_row)
            report($sformatf("out_row %0d, expected %0d", got.out_row, want.out_row));
         if (got.out_col !== want.out_col)
            report($sformatf("out_col %0d, expected %0d", got.out_col, want.out_col));
         if (got.product_value !== want.product_value)
            report($sformatf("product_value %0h, expected %0h at row %0d col %0d",
               got.product_value, want.product_value, want.out_row, want.out_col));
         if (got.last !== want.last)
            report($sformatf("last %0b, expected %0b at row %0d col %0d",
               got.last, want.last, want.out_row, want.out_col));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   imm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   imm_pkg::rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [imm_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [imm_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [imm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   matrix_product_tracker tracker = new();
   bit a_set [64];
   bit b_set [64];
   int idle_pct = 0;
   int items_sent = 0;
   int starts_sent = 0;
   int configs_done = 0;
   int cycles = 0;
   int stall_left = 0;

   integer_matrix_multiply u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("Run did not finish within %0d cycles.", CYCLE_LIMIT);
      $display("tb_top NOT OK");
      $finish;
   end

   always @(negedge clock) begin
      if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(1, 3);
      end
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) begin
         stall_left--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         tracker.check_element(rsp_data);
      end
   end

   function automatic logic [imm_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return $urandom_range(0, 15);
         4: return -$urandom_range(1, 1000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [imm_pkg::DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return 4'd8;
         1: return ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
         2: return 4'($urandom_range(5, 8));
         default: return 4'($urandom_range(1, 4));
      endcase
   endfunction

   task automatic send_req(input imm_pkg::action_type act,
         input logic [imm_pkg::IDX_W-1:0] row, input logic [imm_pkg::IDX_W-1:0] col,
         input logic [imm_pkg::DATA_W-1:0] value);
      imm_pkg::req_type item;
      int gap;
      item.action = act;
      item.elem_row = row;
      item.elem_col = col;
      item.elem_value = value;
      if (items_sent >= CALM_FROM) begin
         idle_pct = 0;
      end
      gap = 0;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 3);
      end
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      tracker.note_transfer(item);
      items_sent++;
      if (act == imm_pkg::ACT_LOAD_A) a_set[{row, col}] = 1'b1;
      if (act == imm_pkg::ACT_LOAD_B) b_set[{row, col}] = 1'b1;
      if (act == imm_pkg::ACT_START) starts_sent++;
   endtask

   task automatic send_noise();
      imm_pkg::action_type act;
      case ($urandom_range(0, 2))
         0: act = imm_pkg::ACT_LOAD_A;
         1: act = imm_pkg::ACT_LOAD_B;
         default: act = imm_pkg::ACT_NONE;
      endcase
      send_req(act, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), pick_value());
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_elements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input imm_pkg::reg_index_type idx, input logic write,
         input logic [imm_pkg::CSR_DATA_W-1:0] value);
      logic [imm_pkg::CSR_DATA_W-1:0] want;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (write) begin
         tracker.write_reg(idx, value);
      end else begin
         want = tracker.reg_value(idx);
         if (csr_prdata !== want)
            tracker.report($sformatf("register %s reads %0h, expected %0h",
               idx.name(), csr_prdata, want));
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_dims(input logic [imm_pkg::DIM_W-1:0] raw_r,
         input logic [imm_pkg::DIM_W-1:0] raw_k, input logic [imm_pkg::DIM_W-1:0] raw_c,
         input bit poke_unused);
      logic [imm_pkg::CSR_DATA_W-1:0] word;
      drain();
      word = $urandom();
      csr_access(imm_pkg::REG_ROWS_A, 1'b1,
         {word[imm_pkg::CSR_DATA_W-1:imm_pkg::DIM_W], raw_r});
      word = $urandom();
      csr_access(imm_pkg::REG_INNER_DIM, 1'b1,
         {word[imm_pkg::CSR_DATA_W-1:imm_pkg::DIM_W], raw_k});
      word = $urandom();
      csr_access(imm_pkg::REG_COLS_B, 1'b1,
         {word[imm_pkg::CSR_DATA_W-1:imm_pkg::DIM_W], raw_c});
      if (poke_unused) begin
         csr_access(imm_pkg::REG_UNUSED, 1'b1, $urandom());
      end
      csr_access(imm_pkg::REG_ROWS_A, 1'b0, '0);
      csr_access(imm_pkg::REG_INNER_DIM, 1'b0, '0);
      csr_access(imm_pkg::REG_COLS_B, 1'b0, '0);
      configs_done++;
   endtask

   task automatic run_phase(input logic [imm_pkg::DIM_W-1:0] raw_r,
         input logic [imm_pkg::DIM_W-1:0] raw_k, input logic [imm_pkg::DIM_W-1:0] raw_c);
      int nr;
      int nk;
      int nc;
      int plan [$];
      int pick;
      set_dims(raw_r, raw_k, raw_c, $urandom_range(0, 2) == 0);
      case ($urandom_range(0, 2))
         0: idle_pct = 0;
         1: idle_pct = 15;
         default: idle_pct = 40;
      endcase
      nr = tracker.clamp_dim(raw_r);
      nk = tracker.clamp_dim(raw_k);
      nc = tracker.clamp_dim(raw_c);
      for (int r = 0; r < nr; r++) begin
         for (int k = 0; k < nk; k++) begin
            if (!a_set[{r[2:0], k[2:0]}] || $urandom_range(0, 9) < 7)
               plan.push_back(r * 8 + k);
         end
      end
      for (int k = 0; k < nk; k++) begin
         for (int c = 0; c < nc; c++) begin
            if (!b_set[{k[2:0], c[2:0]}] || $urandom_range(0, 9) < 7)
               plan.push_back(64 + k * 8 + c);
         end
      end
      plan.shuffle();
      foreach (plan[i]) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         pick = plan[i] % 64;
         send_req(plan[i] >= 64 ? imm_pkg::ACT_LOAD_B : imm_pkg::ACT_LOAD_A,
            3'(pick / 8), 3'(pick % 8), pick_value());
      end
      send_req(imm_pkg::ACT_START, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
         $urandom());
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(0, 3)) send_noise();
         send_req(imm_pkg::ACT_START, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
            $urandom());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset dimensions are all one; a single element whose product wraps.
      idle_pct = 20;
      csr_access(imm_pkg::REG_ROWS_A, 1'b0, '0);
      csr_access(imm_pkg::REG_INNER_DIM, 1'b0, '0);
      csr_access(imm_pkg::REG_COLS_B, 1'b0, '0);
      send_req(imm_pkg::ACT_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
      send_req(imm_pkg::ACT_LOAD_B, 3'd0, 3'd0, 32'hffff_ffff);
      send_req(imm_pkg::ACT_START, 3'd7, 3'd7, 32'hffff_ffff);
      send_req(imm_pkg::ACT_NONE, 3'd7, 3'd7, 32'h5a5a_a5a5);
      // Elements outside the configured dimensions are still stored.
      send_req(imm_pkg::ACT_LOAD_A, 3'd7, 3'd7, 32'h7fff_ffff);
      send_req(imm_pkg::ACT_LOAD_B, 3'd7, 3'd7, 32'h7fff_ffff);

      set_dims(4'd2, 4'd2, 4'd2, 1'b1);
      send_req(imm_pkg::ACT_LOAD_A, 3'd0, 3'd0, 32'h7fff_ffff);
      send_req(imm_pkg::ACT_LOAD_A, 3'd0, 3'd1, 32'h8000_0000);
      send_req(imm_pkg::ACT_LOAD_A, 3'd1, 3'd0, 32'h0000_0001);
      send_req(imm_pkg::ACT_LOAD_A, 3'd1, 3'd1, 32'hffff_ffff);
      send_req(imm_pkg::ACT_LOAD_B, 3'd0, 3'd0, 32'hffff_ffff);
      send_req(imm_pkg::ACT_LOAD_B, 3'd0, 3'd1, 32'h7fff_ffff);
      send_req(imm_pkg::ACT_LOAD_B, 3'd1, 3'd0, 32'h8000_0000);
      send_req(imm_pkg::ACT_LOAD_B, 3'd1, 3'd1, 32'h0000_0000);
      send_req(imm_pkg::ACT_START, 3'd0, 3'd0, 32'h0000_0000);

      // A zero in every dimension register is treated as one.
      set_dims(4'd0, 4'd0, 4'd0, 1'b0);
      send_req(imm_pkg::ACT_START, 3'd2, 3'd5, 32'h1234_5678);

      // Full size, with an over-range column count that clamps to eight.
      run_phase(4'd8, 4'd8, 4'd15);
      while (items_sent < ITEM_TARGET) begin
         run_phase(pick_dim(), pick_dim(), pick_dim());
      end

      idle_pct = 0;
      drain();
      repeat (20) @(posedge clock);
      if (tracker.pending_elements.size() != 0)
         tracker.report($sformatf("%0d product elements never arrived",
            tracker.pending_elements.size()));

      $display("Sent %0d input transfers including %0d multiply starts over %0d dimension settings.",
         items_sent, starts_sent, configs_done);
      $display("Checked %0d product elements, %0d mismatches.",
         tracker.checked, tracker.errors);
      if (tracker.errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
